[rtl/mrd_pkg.sv]
// Shared types, constants and the CRC byte step of the Modbus request deframer.
package mrd_pkg;

  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;
  localparam logic [4:0]  EXT_MARK       = 5'h1F;
  localparam logic [11:0] EXT_BASE       = 12'd248;
  localparam logic [7:0]  FUNC_WR_MULTI  = 8'd16;
  localparam logic [8:0]  LEN_FIXED      = 9'd7;
  localparam logic [8:0]  LEN_WR_MULTI   = 9'd8;
  localparam logic [8:0]  FUNC_OFS_STD   = 9'd1;
  localparam logic [8:0]  FUNC_OFS_EXT   = 9'd2;
  localparam int          STATION_W      = 12;

  typedef enum logic [2:0] {
    ROLE_START,
    ROLE_STN_EXT,
    ROLE_FUNC,
    ROLE_ADDR_HI,
    ROLE_ADDR_LO,
    ROLE_QTY_HI,
    ROLE_QTY_LO,
    ROLE_BODY
  } mrd_role_t;

  typedef struct packed {
    logic [7:0] data;
    mrd_role_t  role;
    logic       frame_end;
    logic       ext;
    logic [8:0] frame_length;
    logic [4:0] frame_index;
  } mrd_token_t;

  typedef struct packed {
    logic        crc_ok;
    logic        station_match;
    logic        extended_format;
    logic [11:0] station;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity_or_value;
    logic [8:0]  frame_length;
    logic [4:0]  frame_index;
  } mrd_result_t;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/mrd_in_if.sv]
// Request channel carrying received packet bytes into the deframer.
interface mrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

[rtl/mrd_out_if.sv]
// Request channel carrying decoded frame headers out of the deframer.
interface mrd_out_if;
  logic        valid;
  logic        ready;
  logic        crc_ok;
  logic        station_match;
  logic        extended_format;
  logic [11:0] station;
  logic [7:0]  function_code;
  logic [15:0] start_address;
  logic [15:0] quantity_or_value;
  logic [8:0]  frame_length;
  logic [4:0]  frame_index;

  modport source (output valid, output crc_ok, output station_match, output extended_format,
                  output station, output function_code, output start_address,
                  output quantity_or_value, output frame_length, output frame_index,
                  input ready);
  modport sink (input valid, input crc_ok, input station_match, input extended_format,
                input station, input function_code, input start_address,
                input quantity_or_value, input frame_length, input frame_index,
                output ready);
endinterface

[rtl/mrd_front.sv]
// Front end: tracks frame position and length and tags every byte with its role.
module mrd_front
  import mrd_pkg::*;
#(
  parameter int MAX_FRAMES = 17
) (
  input  logic        clk,
  input  logic        rst_n,
  mrd_in_if.sink      in_req,
  input  logic        q_full,
  output logic        tok_push,
  output mrd_token_t  tok
);

  logic [8:0] pos_r, pos_nxt;
  logic [8:0] exp_r, exp_nxt;
  logic       ext_r, ext_nxt;
  logic       f16_r, f16_nxt;
  logic [4:0] frames_r, frames_nxt;
  logic       stopped_r, stopped_nxt;

  logic       accept;
  logic       ext_now;
  logic [8:0] fo;
  logic [8:0] rel;
  logic [8:0] len_now;
  logic [8:0] count;
  logic       frame_end;
  mrd_role_t  role;

  assign in_req.ready = !q_full;
  assign accept = in_req.valid && !q_full;

  always_comb begin
    ext_now = (pos_r == 9'd0) ? (in_req.data_byte[7:3] == EXT_MARK) : ext_r;
    fo      = ext_now ? FUNC_OFS_EXT : FUNC_OFS_STD;
    rel     = pos_r - fo;
    count   = pos_r + 9'd1;
    len_now = exp_r;
    f16_nxt = f16_r;
    if (pos_r == 9'd0) begin
      role = ROLE_START;
    end else if (pos_r == 9'd1 && ext_r) begin
      role = ROLE_STN_EXT;
    end else begin
      unique case (rel)
        9'd0:    role = ROLE_FUNC;
        9'd1:    role = ROLE_ADDR_HI;
        9'd2:    role = ROLE_ADDR_LO;
        9'd3:    role = ROLE_QTY_HI;
        9'd4:    role = ROLE_QTY_LO;
        default: role = ROLE_BODY;
      endcase
    end
    if (role == ROLE_FUNC) begin
      f16_nxt = (in_req.data_byte == FUNC_WR_MULTI);
      if (in_req.data_byte != FUNC_WR_MULTI) begin
        len_now = fo + LEN_FIXED;
      end
    end else if (role == ROLE_BODY && rel == 9'd5 && f16_r) begin
      len_now = fo + LEN_WR_MULTI + {1'b0, in_req.data_byte};
    end
    frame_end = (len_now != 9'd0) && (count == len_now);

    tok.data         = in_req.data_byte;
    tok.role         = role;
    tok.frame_end    = frame_end;
    tok.ext          = ext_now;
    tok.frame_length = len_now;
    tok.frame_index  = frames_r;
    tok_push         = accept && !stopped_r;

    pos_nxt     = pos_r;
    exp_nxt     = exp_r;
    ext_nxt     = ext_r;
    frames_nxt  = frames_r;
    stopped_nxt = stopped_r;
    if (accept && !stopped_r) begin
      pos_nxt = count;
      exp_nxt = len_now;
      ext_nxt = ext_now;
      if (frame_end) begin
        pos_nxt    = 9'd0;
        exp_nxt    = 9'd0;
        ext_nxt    = 1'b0;
        f16_nxt    = 1'b0;
        frames_nxt = frames_r + 5'd1;
        if (frames_r == 5'(MAX_FRAMES - 1)) begin
          stopped_nxt = 1'b1;
        end
      end
    end else begin
      f16_nxt = f16_r;
    end
    if (accept && in_req.last_byte) begin
      pos_nxt     = 9'd0;
      exp_nxt     = 9'd0;
      ext_nxt     = 1'b0;
      f16_nxt     = 1'b0;
      frames_nxt  = 5'd0;
      stopped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= 9'd0;
      exp_r     <= 9'd0;
      ext_r     <= 1'b0;
      f16_r     <= 1'b0;
      frames_r  <= 5'd0;
      stopped_r <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      exp_r     <= exp_nxt;
      ext_r     <= ext_nxt;
      f16_r     <= f16_nxt;
      frames_r  <= frames_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

[rtl/mrd_queue.sv]
// Small register queue of tagged bytes between the front and back ends.
module mrd_queue
  import mrd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  mrd_token_t  push_tok,
  output logic        full,
  input  logic        pop,
  output logic        avail,
  output mrd_token_t  pop_tok
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  mrd_token_t    mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push;
  logic          do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign avail   = (cnt_r != '0);
  assign pop_tok = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

[rtl/mrd_back.sv]
// Back end: runs the CRC, captures header fields and registers each frame result.
module mrd_back
  import mrd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,
  input  logic        tok_avail,
  input  mrd_token_t  tok,
  output logic        tok_pop,
  mrd_out_if.source   out_res
);

  logic [11:0] own_station_r;
  logic [15:0] crc_r, crc_nxt;
  logic [11:0] station_r, station_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] qty_r, qty_nxt;
  mrd_result_t res_r, res_nxt;
  logic        res_valid_r, res_valid_nxt;
  logic        slot_free;

  assign slot_free = !res_valid_r || out_res.ready;
  assign tok_pop   = tok_avail && (!tok.frame_end || slot_free);

  always_comb begin
    crc_nxt     = crc16_step((tok.role == ROLE_START) ? CRC_INIT : crc_r, tok.data);
    station_nxt = station_r;
    func_nxt    = func_r;
    addr_nxt    = addr_r;
    qty_nxt     = qty_r;
    unique case (tok.role)
      ROLE_START:   station_nxt = {4'h0, tok.data};
      ROLE_STN_EXT: station_nxt = 12'({station_r[2:0], 8'h00}) + {4'h0, tok.data} + EXT_BASE;
      ROLE_FUNC:    func_nxt = tok.data;
      ROLE_ADDR_HI: addr_nxt = {tok.data, 8'h00};
      ROLE_ADDR_LO: addr_nxt = {addr_r[15:8], tok.data};
      ROLE_QTY_HI:  qty_nxt = {tok.data, 8'h00};
      ROLE_QTY_LO:  qty_nxt = {qty_r[15:8], tok.data};
      ROLE_BODY:    func_nxt = func_r;
      default:      func_nxt = func_r;
    endcase

    res_nxt.crc_ok            = (crc_nxt == 16'h0000);
    res_nxt.station_match     = (station_nxt == own_station_r);
    res_nxt.extended_format   = tok.ext;
    res_nxt.station           = station_nxt;
    res_nxt.function_code     = func_nxt;
    res_nxt.start_address     = addr_nxt;
    res_nxt.quantity_or_value = qty_nxt;
    res_nxt.frame_length      = tok.frame_length;
    res_nxt.frame_index       = tok.frame_index;

    res_valid_nxt = res_valid_r && !out_res.ready;
    if (tok_pop && tok.frame_end) begin
      res_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_station_r <= 12'd1;
      res_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        own_station_r <= cfg_wdata;
      end
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop) begin
      crc_r     <= crc_nxt;
      station_r <= station_nxt;
      func_r    <= func_nxt;
      addr_r    <= addr_nxt;
      qty_r     <= qty_nxt;
      if (tok.frame_end) begin
        res_r <= res_nxt;
      end
    end
  end

  assign out_res.valid             = res_valid_r;
  assign out_res.crc_ok            = res_r.crc_ok;
  assign out_res.station_match     = res_r.station_match;
  assign out_res.extended_format   = res_r.extended_format;
  assign out_res.station           = res_r.station;
  assign out_res.function_code     = res_r.function_code;
  assign out_res.start_address     = res_r.start_address;
  assign out_res.quantity_or_value = res_r.quantity_or_value;
  assign out_res.frame_length      = res_r.frame_length;
  assign out_res.frame_index       = res_r.frame_index;

endmodule

[rtl/modbus_request_deframer.sv]
// Top level of the Modbus RTU request deframer.
// The block takes one packet byte per clock while its queue is not full and
// reports one request per complete frame with its header fields, CRC-16 check
// and station compare. The front end tags each byte with its role in the frame
// and works out the frame length; a QUEUE_DEPTH entry queue feeds the back end,
// which applies one CRC byte step per cycle unless a frame end waits for a free
// output register, which holds the result until the output side is ready. Bytes
// after MAX_FRAMES frames are taken and dropped until the packet's last byte.
module modbus_request_deframer
  import mrd_pkg::*;
#(
  parameter int MAX_FRAMES  = 17,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  mrd_in_if.sink      in_req,
  mrd_out_if.source   out_res,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);

  logic       q_full;
  logic       tok_push;
  mrd_token_t front_tok;
  logic       q_pop;
  logic       q_avail;
  mrd_token_t back_tok;

  mrd_front #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .q_full   (q_full),
    .tok_push (tok_push),
    .tok      (front_tok)
  );

  mrd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (tok_push),
    .push_tok (front_tok),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_tok  (back_tok)
  );

  mrd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .tok_avail (q_avail),
    .tok       (back_tok),
    .tok_pop   (q_pop),
    .out_res   (out_res)
  );

endmodule
